### hw/rtl/query_param_extract_decode_assert.svh
// ----------------------------------------------------------------------------
// query parameter extract/decode assertion macros
// wraps concurrent assertions so they drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef QUERY_PARAM_EXTRACT_DECODE_ASSERT_SVH
`define QUERY_PARAM_EXTRACT_DECODE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define QPED_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qped assertion failed");
// next-cycle implication
`define QPED_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qped assertion failed");
`else
`define QPED_ASSERT(label, clk, rstn, ante, cons)
`define QPED_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/qped_pkg.sv
// ----------------------------------------------------------------------------
// qped_pkg
// types, character constants and helpers for the query parameter decoder
// ----------------------------------------------------------------------------
package qped_pkg;

    localparam int KEY_BYTES      = 8;
    localparam int KEY_TEXT_BYTES = 8;
    localparam int MAX_BEATS      = 4;
    localparam int BEAT_CNT_W     = $clog2(MAX_BEATS + 1);
    localparam int BEAT_IDX_W     = $clog2(MAX_BEATS);

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    typedef enum logic [1:0] {
        CFG_KEY_TEXT    = 2'd0,
        CFG_KEY_LENGTH  = 2'd1,
        CFG_VALUE_LIMIT = 2'd2
    } qped_cfg_idx_t;

    typedef enum logic [1:0] {
        PH_NAME,
        PH_SKIP,
        PH_VALUE,
        PH_DONE
    } qped_phase_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PCT,
        ESC_DIGIT
    } qped_esc_t;

    typedef struct packed {
        logic [7:0] query_byte;
        logic       has_byte;
        logic       end_of_query;
    } qped_in_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       found;
        logic       last;
    } qped_out_t;

    // all results caused by one input item
    typedef struct packed {
        qped_out_t [MAX_BEATS-1:0] beats;
        logic [BEAT_CNT_W-1:0]     count;
    } qped_bundle_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_DIGIT0) && (c <= CH_DIGIT9)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= CH_DIGIT0) && (c <= CH_DIGIT9)) begin
            v = c - CH_DIGIT0;
        end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) begin
            v = c - CH_LOWER_A + 8'd10;
        end else begin
            v = c - CH_UPPER_A + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic qped_out_t data_beat(input logic [7:0] b);
        qped_out_t r;
        r.value_byte = b;
        r.byte_valid = 1'b1;
        r.found      = 1'b0;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic qped_out_t end_beat(input logic fnd);
        qped_out_t r;
        r.value_byte = 8'd0;
        r.byte_valid = 1'b0;
        r.found      = fnd;
        r.last       = 1'b1;
        return r;
    endfunction

endpackage

### hw/rtl/qped_front.sv
// ----------------------------------------------------------------------------
// qped_front
// accepts query bytes, tracks name/value parsing and builds result bundles
// ----------------------------------------------------------------------------
module qped_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  qped_pkg::qped_in_t    s_data,
    output logic                  push_valid,
    input  logic                  push_ready,
    output qped_pkg::qped_bundle_t push_data
);
    import qped_pkg::*;

    logic [63:0] key_text_reg;
    logic [3:0]  key_length_reg;
    logic [5:0]  value_limit_reg;

    qped_phase_t phase_reg, phase_next;
    logic [3:0]  name_pos_reg, name_pos_next;
    logic        mismatch_reg, mismatch_next;
    logic [5:0]  raw_count_reg, raw_count_next;
    qped_esc_t   esc_reg, esc_next;
    logic [7:0]  held_reg, held_next;
    logic        match_reg, match_next;

    logic accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_text_reg    <= 64'd0;
            key_length_reg  <= 4'd0;
            value_limit_reg <= 6'd63;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_KEY_TEXT:    key_text_reg    <= cfg_data;
                CFG_KEY_LENGTH:  key_length_reg  <= cfg_data[3:0];
                CFG_VALUE_LIMIT: value_limit_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_NAME;
            name_pos_reg  <= 4'd0;
            mismatch_reg  <= 1'b0;
            raw_count_reg <= 6'd0;
            esc_reg       <= ESC_NONE;
            held_reg      <= 8'd0;
            match_reg     <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            name_pos_reg  <= name_pos_next;
            mismatch_reg  <= mismatch_next;
            raw_count_reg <= raw_count_next;
            esc_reg       <= esc_next;
            held_reg      <= held_next;
            match_reg     <= match_next;
        end
    end

    always_comb begin
        logic [3:0]                klen;
        logic [7:0]                b;
        logic [7:0]                kc;
        logic [7:0]                dec;
        logic                      plain;
        logic [BEAT_CNT_W-1:0]     n;
        qped_out_t [MAX_BEATS-1:0] beats;

        b     = s_data.query_byte;
        klen  = (key_length_reg > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_length_reg;
        kc    = (name_pos_reg >= 4'(KEY_TEXT_BYTES)) ? 8'd0
              : key_text_reg[{name_pos_reg[2:0], 3'b000} +: 8];
        dec   = {hex_val(held_reg), hex_val(b)};
        plain = 1'b0;
        n     = '0;
        beats = '0;

        phase_next     = phase_reg;
        name_pos_next  = name_pos_reg;
        mismatch_next  = mismatch_reg;
        raw_count_next = raw_count_reg;
        esc_next       = esc_reg;
        held_next      = held_reg;
        match_next     = match_reg;

        if (accept && s_data.has_byte) begin
            unique case (phase_reg)
                PH_NAME: begin
                    if (b == CH_AMP) begin
                        name_pos_next = 4'd0;
                        mismatch_next = 1'b0;
                    end else if (b == CH_EQ) begin
                        if (!mismatch_reg && name_pos_reg == klen && !match_reg) begin
                            match_next     = 1'b1;
                            phase_next     = PH_VALUE;
                            raw_count_next = 6'd0;
                            esc_next       = ESC_NONE;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end else begin
                        if (name_pos_reg >= klen || kc != b) begin
                            mismatch_next = 1'b1;
                        end
                        if (name_pos_reg != 4'd15) begin
                            name_pos_next = name_pos_reg + 4'd1;
                        end
                    end
                end
                PH_SKIP: begin
                    if (b == CH_AMP) begin
                        phase_next    = PH_NAME;
                        name_pos_next = 4'd0;
                        mismatch_next = 1'b0;
                    end
                end
                PH_VALUE: begin
                    if (b == CH_AMP) begin
                        // pending escape goes out literally
                        if (esc_reg != ESC_NONE) begin
                            beats[n[BEAT_IDX_W-1:0]] = data_beat(CH_PCT);
                            n = n + 1'b1;
                        end
                        if (esc_reg == ESC_DIGIT) begin
                            beats[n[BEAT_IDX_W-1:0]] = data_beat(held_reg);
                            n = n + 1'b1;
                        end
                        esc_next   = ESC_NONE;
                        phase_next = PH_DONE;
                    end else if (raw_count_reg < value_limit_reg) begin
                        raw_count_next = raw_count_reg + 6'd1;
                        unique case (esc_reg)
                            ESC_PCT: begin
                                if (is_hex(b)) begin
                                    held_next = b;
                                    esc_next  = ESC_DIGIT;
                                end else begin
                                    beats[n[BEAT_IDX_W-1:0]] = data_beat(CH_PCT);
                                    n = n + 1'b1;
                                    esc_next = ESC_NONE;
                                    plain    = 1'b1;
                                end
                            end
                            ESC_DIGIT: begin
                                esc_next = ESC_NONE;
                                if (is_hex(b)) begin
                                    if (dec == CH_NUL) begin
                                        phase_next = PH_DONE;
                                    end else begin
                                        beats[n[BEAT_IDX_W-1:0]] = data_beat(dec);
                                        n = n + 1'b1;
                                    end
                                end else begin
                                    beats[n[BEAT_IDX_W-1:0]] = data_beat(CH_PCT);
                                    n = n + 1'b1;
                                    beats[n[BEAT_IDX_W-1:0]] = data_beat(held_reg);
                                    n = n + 1'b1;
                                    plain = 1'b1;
                                end
                            end
                            default: plain = 1'b1;
                        endcase
                        if (plain) begin
                            if (b == CH_PLUS) begin
                                beats[n[BEAT_IDX_W-1:0]] = data_beat(CH_SPACE);
                                n = n + 1'b1;
                            end else if (b == CH_PCT) begin
                                esc_next = ESC_PCT;
                            end else if (b == CH_NUL) begin
                                phase_next = PH_DONE;
                                esc_next   = ESC_NONE;
                            end else begin
                                beats[n[BEAT_IDX_W-1:0]] = data_beat(b);
                                n = n + 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (accept && s_data.end_of_query) begin
            if (phase_next == PH_VALUE) begin
                if (esc_next != ESC_NONE) begin
                    beats[n[BEAT_IDX_W-1:0]] = data_beat(CH_PCT);
                    n = n + 1'b1;
                end
                if (esc_next == ESC_DIGIT) begin
                    beats[n[BEAT_IDX_W-1:0]] = data_beat(held_next);
                    n = n + 1'b1;
                end
            end
            beats[n[BEAT_IDX_W-1:0]] = end_beat(match_next);
            n = n + 1'b1;
            phase_next     = PH_NAME;
            name_pos_next  = 4'd0;
            mismatch_next  = 1'b0;
            raw_count_next = 6'd0;
            esc_next       = ESC_NONE;
            held_next      = 8'd0;
            match_next     = 1'b0;
        end

        push_valid      = accept && (n != '0);
        push_data.beats = beats;
        push_data.count = n;
    end

endmodule

### hw/rtl/qped_queue.sv
// ----------------------------------------------------------------------------
// qped_queue
// small bundle queue between the front and back halves
// ----------------------------------------------------------------------------
module qped_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  qped_pkg::qped_bundle_t  push_data,
    output logic                    head_valid,
    input  logic                    pop,
    output qped_pkg::qped_bundle_t  head_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    import qped_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    qped_bundle_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]    level_reg, level_next;
    logic                do_push, do_pop;

    assign push_ready = (level_reg != LVL_W'(DEPTH));
    assign head_valid = (level_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            level_next = level_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/qped_back.sv
// ----------------------------------------------------------------------------
// qped_back
// walks each queued bundle and drives one result beat per cycle while the sink is ready
// ----------------------------------------------------------------------------
module qped_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   head_valid,
    input  qped_pkg::qped_bundle_t head_data,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output qped_pkg::qped_out_t    m_data
);
    import qped_pkg::*;

    logic [BEAT_IDX_W-1:0] idx_reg, idx_next;
    logic                  m_valid_reg, m_valid_next;
    qped_out_t             m_data_reg, m_data_next;
    logic                  load;
    logic                  last_beat;

    assign load      = head_valid && (!m_valid_reg || m_ready);
    assign last_beat = (BEAT_CNT_W'(idx_reg) + 1'b1) == head_data.count;
    assign pop       = load && last_beat;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = head_data.beats[idx_reg];
            idx_next     = last_beat ? '0 : idx_reg + 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

### hw/rtl/query_param_extract_decode.sv
// ----------------------------------------------------------------------------
// query_param_extract_decode
// pulls one named parameter out of a URL query and percent-decodes its value
// ----------------------------------------------------------------------------
// One query byte is accepted per cycle whenever the bundle queue has room;
// the front half classifies it in that cycle and queues the zero to four
// result beats it causes (most bytes make one or none, a closing item up to
// four). The back half sends those beats one per cycle while the sink is
// ready, from an output register; each beat passes through the bundle queue
// and then the output register before the sink sees it. QUEUE_DEPTH bundles
// absorb bursts when the sink stalls. Config writes are always ready and
// are registered before they take effect.
`include "query_param_extract_decode_assert.svh"

module query_param_extract_decode #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  qped_pkg::qped_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output qped_pkg::qped_out_t m_data
);
    import qped_pkg::*;

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic         push_valid;
    logic         push_ready;
    qped_bundle_t push_data;
    logic         head_valid;
    qped_bundle_t head_data;
    logic         pop;
    logic [LVL_W-1:0] q_level;

    assign cfg_ready = 1'b1;

    qped_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    qped_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .head_valid (head_valid),
        .pop        (pop),
        .head_data  (head_data),
        .level      (q_level)
    );

    qped_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // a bundle never claims more beats than it has slots
    `QPED_ASSERT(a_push_count, aclk, aresetn, push_valid, (push_data.count != '0) && (push_data.count <= BEAT_CNT_W'(MAX_BEATS)))
    // a closing beat must sit in the queue right after its item
    `QPED_ASSERT_NEXT(a_end_queued, aclk, aresetn, s_valid && s_ready && s_data.end_of_query, q_level != '0)
    // the final marker never carries a value byte
    `QPED_ASSERT(a_marker_shape, aclk, aresetn, m_valid && m_data.last, !m_data.byte_valid)

endmodule
